FILE: rtl/core/round_robin_capped_worker_select_unit_assert.svh
// Assertion macros shared by the checkers of the worker select unit.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ROUND_ROBIN_CAPPED_WORKER_SELECT_UNIT_ASSERT_SVH
`define ROUND_ROBIN_CAPPED_WORKER_SELECT_UNIT_ASSERT_SVH

// Overlapping implication, checked at every rising clock edge out of reset.
`define RCWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define RCWS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rcws_pkg.sv
// Package of the round robin capped worker select unit: sizes, codes and types.
// Used by every module of the block but rcws_ram; depends on nothing.
package rcws_pkg;

  // Size of the link count store and the width of its address.
  localparam int unsigned MaxWorkers = 256;
  localparam int unsigned AddrW      = $clog2(MaxWorkers);

  // Field widths.
  localparam int unsigned WorkerW  = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned LinkW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Highest number of workers that can take part in a search.
  localparam int unsigned ActiveCap = (MaxWorkers < 256) ? MaxWorkers : 256;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_WORKER_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LINKS    = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] WorkerCountRst = 9'd1;
  localparam logic [LinkW-1:0]  MaxLinksRst    = 16'd64;

  // Result codes.
  typedef enum logic [1:0] {
    STAT_ASSIGNED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RELEASED = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SEARCH,
    S_RELCHK,
    S_RESULT
  } state_e;

  // Access from the controller to the link count store.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [LinkW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/rcws_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; contents are undefined until written.
module rcws_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/rcws_store.sv
// Link count store: one RAM of counts plus a valid bit per entry cleared at reset.
// Depends on rcws_pkg and rcws_ram; an entry never written reads as zero.
module rcws_store
  import rcws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  output logic [LinkW-1:0] rdata_o
);

  logic [MaxWorkers-1:0] valid_q;
  logic [AddrW-1:0]      raddr_q;
  logic [LinkW-1:0]      ram_rdata;

  rcws_ram #(
    .Width(LinkW),
    .Depth(MaxWorkers)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // The read address follows the RAM's read latency.
  always_ff @(posedge clk_i) begin
    raddr_q <= req_i.raddr;
  end

  assign rdata_o = valid_q[raddr_q] ? ram_rdata : '0;

endmodule

FILE: rtl/core/rcws_mod.sv
// Remainder unit for the pointer advance: restoring division, one bit a cycle.
// Depends on rcws_pkg; a dividend below the divisor skips the iteration.
module rcws_mod
  import rcws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CountW-1:0]  dividend_i,
  input  logic [CountW-1:0]  divisor_i,
  output logic               done_o,
  output logic [WorkerW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(CountW + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [CountW-1:0] dvd_q;
  logic [CountW-1:0] rem_q;
  logic [CountW:0]   trial;
  logic [CountW:0]   step;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[CountW-1]};
    if (trial >= {1'b0, divisor_i}) begin
      step = trial - {1'b0, divisor_i};
    end else begin
      step = trial;
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (dividend_i < divisor_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(CountW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (dividend_i < divisor_i) begin
        rem_q <= dividend_i;
      end else begin
        rem_q <= '0;
        dvd_q <= dividend_i;
      end
    end else if (busy_q) begin
      rem_q <= step[CountW-1:0];
      dvd_q <= {dvd_q[CountW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = WorkerW'(rem_q);

endmodule

FILE: rtl/core/rcws_ctrl.sv
// Controller: configuration registers, rotate pointer, search sequencer and result register.
// Depends on rcws_pkg; drives the link count store and the remainder unit.
module rcws_ctrl
  import rcws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [WorkerW-1:0]  release_worker_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [WorkerW-1:0]  chosen_worker_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output mem_req_t            mem_req_o,
  input  logic [LinkW-1:0]    mem_rdata_i,
  output logic                mod_start_o,
  output logic [CountW-1:0]   mod_dividend_o,
  output logic [CountW-1:0]   mod_divisor_o,
  input  logic                mod_done_i,
  input  logic [WorkerW-1:0]  mod_rem_i
);

  state_e             state_q, state_d;
  logic [CountW-1:0]  wc_q;
  logic [LinkW-1:0]   cap_q;
  logic [WorkerW-1:0] ptr_q;
  logic [WorkerW-1:0] idx_q, idx_next;
  logic [CountW-1:0]  issued_q;
  logic               pend_q;
  logic [WorkerW-1:0] pend_addr_q;
  logic [AddrW-1:0]   rel_addr_q;
  logic               rel_ok_q;
  status_e            res_status_q;
  logic [WorkerW-1:0] res_worker_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [WorkerW-1:0] out_worker_q;
  logic [CountW-1:0]  n_active;
  logic               accept, hit, search_last, issue, out_free, out_load, rel_take;

  // Active worker count, limited by the store size.
  assign n_active = (wc_q > CountW'(ActiveCap)) ? CountW'(ActiveCap) : wc_q;

  // Handshake and search conditions.
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign hit         = pend_q && (mem_rdata_i < cap_q);
  assign search_last = pend_q && !hit && (issued_q == n_active);
  assign issue       = (state_q == S_SEARCH) && !hit && (issued_q != n_active);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_RESULT) && out_free;
  assign rel_take    = rel_ok_q && (mem_rdata_i != '0);
  assign idx_next    = (({1'b0, idx_q} + CountW'(1)) == n_active) ? '0 : idx_q + WorkerW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i) begin
            state_d = S_RELCHK;
          end else if (n_active == '0) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done_i) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || search_last) begin
          state_d = S_RESULT;
        end
      end
      S_RELCHK: state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs toward the store, the remainder unit and the input side.
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.raddr = AddrW'(release_worker_i);
    mod_start_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        mod_start_o = accept && !operation_i && (n_active != '0);
      end
      S_SEARCH: begin
        mem_req_o.raddr = AddrW'(idx_q);
        mem_req_o.we    = hit;
        mem_req_o.waddr = AddrW'(pend_addr_q);
        mem_req_o.wdata = mem_rdata_i + LinkW'(1);
      end
      S_RELCHK: begin
        mem_req_o.we    = rel_take;
        mem_req_o.waddr = rel_addr_q;
        mem_req_o.wdata = mem_rdata_i - LinkW'(1);
      end
      S_MOD, S_RESULT: begin
        mem_req_o.we = 1'b0;
      end
      default: begin
        mem_req_o.we = 1'b0;
      end
    endcase
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign mod_dividend_o = {1'b0, ptr_q} + CountW'(1);
  assign mod_divisor_o  = n_active;
  assign cfg_ready_o    = 1'b1;

  // Control registers: state, configuration, pointer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wc_q        <= WorkerCountRst;
      cap_q       <= MaxLinksRst;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_WORKER_COUNT) begin
          wc_q <= cfg_data_i[CountW-1:0];
        end else if (cfg_index_i == REG_MAX_LINKS) begin
          cap_q <= cfg_data_i[LinkW-1:0];
        end
      end
      if ((state_q == S_MOD) && mod_done_i) begin
        ptr_q  <= mod_rem_i;
        pend_q <= 1'b0;
      end else if (state_q == S_SEARCH) begin
        pend_q <= issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search and result datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rel_addr_q   <= AddrW'(release_worker_i);
      rel_ok_q     <= (32'(release_worker_i) < MaxWorkers);
      res_status_q <= STAT_FULL;
      res_worker_q <= '0;
    end
    if ((state_q == S_MOD) && mod_done_i) begin
      idx_q    <= mod_rem_i;
      issued_q <= '0;
    end
    if (issue) begin
      pend_addr_q <= idx_q;
      idx_q       <= idx_next;
      issued_q    <= issued_q + CountW'(1);
    end
    if ((state_q == S_SEARCH) && hit) begin
      res_status_q <= STAT_ASSIGNED;
      res_worker_q <= pend_addr_q;
    end
    if (state_q == S_RELCHK) begin
      res_status_q <= rel_take ? STAT_RELEASED : STAT_IGNORED;
      res_worker_q <= '0;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_worker_q <= res_worker_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign chosen_worker_o = out_worker_q;

endmodule

FILE: rtl/core/round_robin_capped_worker_select_unit.sv
// Round robin worker selector with a per-worker link cap. One request at a time is taken;
// a release passes through the release check state, then the result state, which loads the
// output register once it is free. An assign advances the pointer in the remainder unit,
// which skips its division when the incremented pointer is below the active worker count,
// then searches 1 to the active count of workers, one link count read a cycle from the
// count RAM, and loads the result in the same way. Link counts are cleared at reset by
// per-entry valid bits, so no clearing pass is needed. Results wait in an output register,
// so the next request is taken while a result is still stalled.
// Depends on rcws_pkg, rcws_ctrl, rcws_mod, rcws_store and rcws_ram.
module round_robin_capped_worker_select_unit
  import rcws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [WorkerW-1:0]  release_worker_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [WorkerW-1:0]  chosen_worker_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  mem_req_t           mem_req;
  logic [LinkW-1:0]   mem_rdata;
  logic               mod_start, mod_done;
  logic [CountW-1:0]  mod_dividend, mod_divisor;
  logic [WorkerW-1:0] mod_rem;

  // Sequencer and registers.
  rcws_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .release_worker_i(release_worker_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .chosen_worker_o (chosen_worker_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .mod_start_o     (mod_start),
    .mod_dividend_o  (mod_dividend),
    .mod_divisor_o   (mod_divisor),
    .mod_done_i      (mod_done),
    .mod_rem_i       (mod_rem)
  );

  // Pointer wrap remainder.
  rcws_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(mod_dividend),
    .divisor_i (mod_divisor),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // Link counts.
  rcws_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

endmodule

FILE: rtl/core/rcws_checker.sv
// Port-level checker of the worker select unit, bound to the top level.
// Depends on rcws_pkg and the assertion macro header.
`include "round_robin_capped_worker_select_unit_assert.svh"

module rcws_checker
  import rcws_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          status_o,
  input logic [WorkerW-1:0]  chosen_worker_o
);

  // A stalled result holds its value.
  `RCWS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(chosen_worker_o), "stalled result changed")

  // Only an assigned result names a worker.
  `RCWS_ASSERT_IMP(a_worker_zero, clk_i, rst_ni, out_valid_o && (status_o != STAT_ASSIGNED), chosen_worker_o == '0, "worker set on a result other than assigned")

  // A request in work blocks the next one in the following cycle.
  `RCWS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while another is in work")

  // A new result only appears after a request has been worked on.
  `RCWS_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without a request in work")

endmodule

bind round_robin_capped_worker_select_unit rcws_checker u_rcws_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench of round_robin_capped_worker_select_unit: a directed table, then phases of random
// assign and release requests under several worker counts and link caps, all checked in order
// against a predictor of the rotate pointer and link counts. Depends on rcws_pkg and the RTL.
module tb;
  import rcws_pkg::*;

  // Request operations and configuration indexes that decode to no register.
  localparam logic OP_ASSIGN  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  // Run limits, in clock cycles or requests.
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned TailItems   = 100;
  localparam int unsigned NumPhases   = 9;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  // One line of the directed table: a request or a register write.
  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [WorkerW-1:0]  worker;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] data;
    logic                has_exp;
    status_e             exp_status;
    logic [WorkerW-1:0]  exp_worker;
  } dir_row_t;

  typedef struct packed {
    status_e            status;
    logic [WorkerW-1:0] worker;
  } link_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                operation_i;
  logic [WorkerW-1:0]  release_worker_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [WorkerW-1:0]  chosen_worker_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  round_robin_capped_worker_select_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .release_worker_i (release_worker_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .chosen_worker_o  (chosen_worker_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Predictor copy of the configuration and state.
  logic [CountW-1:0]  cfg_workers;
  logic [LinkW-1:0]   cfg_cap;
  logic [WorkerW-1:0] rot_ptr;
  logic [LinkW-1:0]   link_cnt [MaxWorkers];

  link_result_t pending_results [$];
  int unsigned  n_err, n_req, n_res, n_cfg, idle_cycles;
  int unsigned  n_assigned, n_full, n_released, n_ignored;
  bit           quiet_tail, hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Number of workers that an assign searches.
  function automatic int unsigned active_workers();
    int unsigned n;
    n = cfg_workers;
    if (n > ActiveCap) n = ActiveCap;
    return n;
  endfunction

  // Advance the predictor by one request and return the result it must produce.
  function automatic link_result_t predict_link_result(input logic op,
                                                       input logic [WorkerW-1:0] rel);
    link_result_t res;
    int unsigned  n;
    int unsigned  idx;
    bit           found;
    res.status = STAT_FULL;
    res.worker = '0;
    found      = 1'b0;
    if (op == OP_ASSIGN) begin
      n = active_workers();
      if (n > 0) begin
        rot_ptr = WorkerW'((int'(rot_ptr) + 1) % n);
        for (int unsigned i = 0; i < n; i++) begin
          idx = (int'(rot_ptr) + i) % n;
          if (!found && link_cnt[idx] < cfg_cap) begin
            link_cnt[idx] = link_cnt[idx] + 1'b1;
            res.status    = STAT_ASSIGNED;
            res.worker    = WorkerW'(idx);
            found         = 1'b1;
          end
        end
      end
    end else if (int'(rel) < MaxWorkers && link_cnt[rel] != '0) begin
      link_cnt[rel] = link_cnt[rel] - 1'b1;
      res.status    = STAT_RELEASED;
    end else begin
      res.status = STAT_IGNORED;
    end
    return res;
  endfunction

  function automatic dir_row_t req_row(input logic op, input logic [WorkerW-1:0] wk,
                                       input logic has_exp, input status_e st,
                                       input logic [WorkerW-1:0] exp_wk);
    dir_row_t r;
    r            = '0;
    r.kind       = ROW_REQ;
    r.op         = op;
    r.worker     = wk;
    r.has_exp    = has_exp;
    r.exp_status = st;
    r.exp_worker = exp_wk;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] data);
    dir_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.data    = data;
    return r;
  endfunction

  // Offer one request, possibly after an idle gap, and log its expected result on acceptance.
  task automatic send_request(input logic op, input logic [WorkerW-1:0] rel,
                              input logic has_exp, input status_e exp_st,
                              input logic [WorkerW-1:0] exp_wk);
    link_result_t pred;
    cfg_valid_i <= 1'b0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    release_worker_i <= rel;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = predict_link_result(op, rel);
    if (has_exp) begin
      pred.status = exp_st;
      pred.worker = exp_wk;
    end
    pending_results = {pending_results, pred};
    n_req++;
  endtask

  // Write one register once every outstanding result has come back.
  // The valid stays high on return; the next request lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_WORKER_COUNT: cfg_workers = data[CountW-1:0];
      REG_MAX_LINKS:    cfg_cap     = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    link_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_res++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, chosen_worker %0d", status_o, chosen_worker_o);
        n_err++;
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          STAT_ASSIGNED: n_assigned++;
          STAT_FULL:     n_full++;
          STAT_RELEASED: n_released++;
          default:       n_ignored++;
        endcase
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          n_err++;
        end
        if (chosen_worker_o !== want.worker) begin
          $error("chosen_worker: expected %0d, actual %0d", want.worker, chosen_worker_o);
          n_err++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output stall driver: random bursts, one long hold-off on request, none in the tail.
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_pending = 1'b0;
      end else if (quiet_tail || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    dir_row_t           dir_tab [$];
    int unsigned        ph_workers [NumPhases];
    int unsigned        ph_cap [NumPhases];
    int unsigned        ph_items [NumPhases];
    int unsigned        ph_assign_pct [NumPhases];
    int unsigned        total_rand;
    int unsigned        sent_rand;
    int unsigned        n;
    logic               op;
    logic [WorkerW-1:0] rel;

    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    operation_i      <= OP_ASSIGN;
    release_worker_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= REG_WORKER_COUNT;
    cfg_data_i       <= '0;
    quiet_tail       = 1'b0;
    hold_pending     = 1'b0;
    cfg_workers      = WorkerCountRst;
    cfg_cap          = MaxLinksRst;
    rot_ptr          = '0;
    foreach (link_cnt[i]) link_cnt[i] = '0;

    // Directed part: reset defaults, no workers, zero cap, full set, index extremes,
    // stale pointer after a shrink, and releases outside the active set.
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd0,   1'b1, STAT_RELEASED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd0,   1'b1, STAT_IGNORED,  8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd255, 1'b1, STAT_IGNORED,  8'd0)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd255, 1'b1, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_WORKER_COUNT, 16'd0)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_FULL,     8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd0,   1'b1, STAT_RELEASED, 8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_WORKER_COUNT, 16'd3)};
    dir_tab = {dir_tab, cfg_row(REG_MAX_LINKS, 16'd0)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_FULL,     8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_MAX_LINKS, 16'd1)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_ASSIGNED, 8'd2)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_ASSIGNED, 8'd1)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b1, STAT_FULL,     8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd2,   1'b1, STAT_RELEASED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b0, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd200, 1'b1, STAT_IGNORED,  8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_WORKER_COUNT, 16'd256)};
    dir_tab = {dir_tab, cfg_row(REG_MAX_LINKS, 16'hFFFF)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd0,   1'b0, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd255, 1'b1, STAT_IGNORED,  8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_WORKER_COUNT, 16'd511)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd170, 1'b0, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_WORKER_COUNT, 16'd2)};
    dir_tab = {dir_tab, req_row(OP_ASSIGN,  8'd85,  1'b0, STAT_ASSIGNED, 8'd0)};
    dir_tab = {dir_tab, cfg_row(REG_SPARE_2, 16'hFFFF)};
    dir_tab = {dir_tab, cfg_row(REG_SPARE_3, 16'h0000)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd2,   1'b1, STAT_RELEASED, 8'd0)};
    dir_tab = {dir_tab, req_row(OP_RELEASE, 8'd2,   1'b0, STAT_RELEASED, 8'd0)};

    // Random phases: worker count, link cap, request count and share of assigns.
    ph_workers = '{4, 256, 256, 7, 0, 1, 511, 0, 5};
    ph_cap     = '{3, 65535, 1, 2, 5, 1, 2, 0, 4};
    ph_items   = '{120, 80, 300, 100, 20, 40, 60, 80, 120};
    ph_assign_pct = '{70, 60, 85, 60, 50, 60, 60, 65, 60};
    ph_workers[7] = $urandom_range(2, 16);
    ph_cap[7]     = $urandom_range(1, 8);
    total_rand = 0;
    foreach (ph_items[p]) total_rand += ph_items[p];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].data);
      end else begin
        send_request(dir_tab[i].op, dir_tab[i].worker, dir_tab[i].has_exp,
                     dir_tab[i].exp_status, dir_tab[i].exp_worker);
      end
    end

    sent_rand = 0;
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(REG_WORKER_COUNT, CfgDataW'(ph_workers[p]));
      write_reg(REG_MAX_LINKS, CfgDataW'(ph_cap[p]));
      for (int k = 0; k < ph_items[p]; k++) begin
        // Fill the output register and stall the input once.
        if (p == 2 && k == 150) hold_pending = 1'b1;
        if (total_rand - sent_rand <= TailItems) quiet_tail = 1'b1;
        n   = active_workers();
        op  = ($urandom_range(1, 100) <= ph_assign_pct[p]) ? OP_ASSIGN : OP_RELEASE;
        rel = WorkerW'($urandom_range(0, 255));
        // Most releases target a worker of the active set; the rest are anywhere.
        if (op == OP_RELEASE && n > 0 && $urandom_range(0, 9) != 0)
          rel = WorkerW'($urandom_range(0, n - 1));
        send_request(op, rel, 1'b0, STAT_ASSIGNED, '0);
        sent_rand++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests in %0d results: %0d assigned, %0d full, %0d released, %0d ignored.",
             n_req, n_res, n_assigned, n_full, n_released, n_ignored);
    $display("Used %0d register writes, worker counts 0 to 511, caps 0 to 65535, one long hold-off.",
             n_cfg);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rcws_pkg.sv
rtl/core/rcws_ram.sv
rtl/core/rcws_store.sv
rtl/core/rcws_mod.sv
rtl/core/rcws_ctrl.sv
rtl/core/round_robin_capped_worker_select_unit.sv
rtl/core/rcws_checker.sv
tb/tb.sv
